### rtl/pis_pkg.sv
// shared types, constants and helpers of the plasma ion source term block
package pis_pkg;

	localparam int DATA_W        = 32;
	localparam int CFG_W         = 31;
	localparam int IDX_W         = 3;
	localparam int DIV_N         = 31;
	localparam int FRAC_BITS_DEF = 16;

	// register indexes of the configuration port
	typedef enum logic [IDX_W-1:0] {
		IDX_ION_MASS      = 3'd0,
		IDX_INV_ION_MASS  = 3'd1,
		IDX_LIGHT_SPEED   = 3'd2,
		IDX_SLOWING_SLOPE = 3'd3,
		IDX_FIXED_RATE    = 3'd4,
		IDX_TRIGGER_LEVEL = 3'd5
	} cfg_idx_t;

	// per-point values that ride along the drag path
	typedef struct packed {
		logic signed [DATA_W-1:0] q;
		logic signed [DATA_W-1:0] j1;
		logic signed [DATA_W-1:0] j2;
		logic signed [DATA_W-1:0] j3;
		logic signed [DATA_W-1:0] m3;
		logic signed [DATA_W-1:0] b1;
		logic signed [DATA_W-1:0] b2;
		logic signed [DATA_W-1:0] e3;
		logic                     sat;
		logic                     ramp;
		logic                     pos;
	} carry_t;

	// clip a wide signed value to 32 bits
	function automatic logic [DATA_W:0] sat32(input logic signed [65:0] v);
		logic [DATA_W:0] res;
		if (v > 66'sd2147483647) begin
			res = {1'b1, 32'h7fff_ffff};
		end else if (v < -66'sd2147483648) begin
			res = {1'b1, 32'h8000_0000};
		end else begin
			res = {1'b0, v[DATA_W-1:0]};
		end
		return res;
	endfunction

endpackage

### rtl/pis_in_if.sv
// input channel of the plasma ion source term block
interface pis_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] ion_density;
	logic signed [31:0] momentum_x;
	logic signed [31:0] momentum_y;
	logic signed [31:0] momentum_z;
	logic signed [31:0] field_bx;
	logic signed [31:0] field_by;
	logic signed [31:0] field_ez;

	modport source (output valid, ion_density, momentum_x, momentum_y, momentum_z,
		field_bx, field_by, field_ez, input ready);
	modport sink (input valid, ion_density, momentum_x, momentum_y, momentum_z,
		field_bx, field_by, field_ez, output ready);
endinterface

### rtl/pis_out_if.sv
// result channel of the plasma ion source term block
interface pis_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] src_momentum_x;
	logic signed [31:0] src_momentum_y;
	logic signed [31:0] src_momentum_z;
	logic signed [31:0] src_energy;
	logic signed [31:0] src_efield_z;
	logic               saturated;
	logic               bad_density;

	modport source (output valid, src_momentum_x, src_momentum_y, src_momentum_z,
		src_energy, src_efield_z, saturated, bad_density, input ready);
	modport sink (input valid, src_momentum_x, src_momentum_y, src_momentum_z,
		src_energy, src_efield_z, saturated, bad_density, output ready);
endinterface

### rtl/plasma_ion_source_term.sv
// plasma ion source term: lorentz, energy, field and drag sources per grid point
//
// One grid point enters as a beat on in_ch (density, three momenta, B1, B2, E3)
// and leaves as one beat on out_ch with five saturated Q16.16 sources and the
// saturated and bad_density flags. Six registers are written through the
// plain write port cfg_we / cfg_index / cfg_data; the user must write them
// only while no point is in flight; the block itself does not enforce it. One
// point per cycle while out_ch is not stalled. Two input stages, 31 stages of
// the restoring divider for mass*|M3|/density (one quotient bit per stage),
// then six stages for drag multiply, source products, rounding and saturation.
// Each stage has its own valid bit and a ready chain, so a stalled receiver
// holds the output register while bubbles further back still close up;
// nothing is dropped or repeated. Reset clears all valid bits and loads the
// register defaults (unit mass, unit inverse mass, unit light speed squared,
// fixed drag of zero).
module plasma_ion_source_term #(
	parameter int FRAC_BITS = pis_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [pis_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pis_pkg::CFG_W-1:0]   cfg_data,
	pis_in_if.sink                      in_ch,
	pis_out_if.source                   out_ch
);
	import pis_pkg::*;

	localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);
	localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;
	localparam logic [CFG_W-1:0] MAX31 = {CFG_W{1'b1}};

	function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
		return (p + $signed(HALF)) >>> FRAC_BITS;
	endfunction

	// configuration registers
	logic [CFG_W-1:0] mass_q, inv_q, lss_q, slope_q, fixed_q, trig_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q  <= ONE;
			inv_q   <= ONE;
			lss_q   <= ONE;
			slope_q <= '0;
			fixed_q <= '0;
			trig_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				IDX_ION_MASS:      mass_q  <= cfg_data;
				IDX_INV_ION_MASS:  inv_q   <= cfg_data;
				IDX_LIGHT_SPEED:   lss_q   <= cfg_data;
				IDX_SLOWING_SLOPE: slope_q <= cfg_data;
				IDX_FIXED_RATE:    fixed_q <= cfg_data;
				IDX_TRIGGER_LEVEL: trig_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid and ready chain
	logic v_s1, v_s2, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic r_s1, r_s2, r_s4, r_s5, r_s6, r_s7, r_s8, r_s9;
	logic [DIV_N-1:0] v_s3, r_s3;

	assign r_s9 = !v_s9 || out_ch.ready;
	assign r_s8 = !v_s8 || r_s9;
	assign r_s7 = !v_s7 || r_s8;
	assign r_s6 = !v_s6 || r_s7;
	assign r_s5 = !v_s5 || r_s6;
	assign r_s4 = !v_s4 || r_s5;
	assign r_s3[DIV_N-1] = !v_s3[DIV_N-1] || r_s4;
	for (genvar k = 0; k < DIV_N - 1; k++) begin : g_rdy
		assign r_s3[k] = !v_s3[k] || r_s3[k+1];
	end
	assign r_s2 = !v_s2 || r_s3[0];
	assign r_s1 = !v_s1 || r_s2;
	assign in_ch.ready = r_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= '0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0;
		end else begin
			if (r_s1) v_s1 <= in_ch.valid;
			if (r_s2) v_s2 <= v_s1;
			if (r_s3[0]) v_s3[0] <= v_s2;
			for (int k = 1; k < DIV_N; k++) begin
				if (r_s3[k]) v_s3[k] <= v_s3[k-1];
			end
			if (r_s4) v_s4 <= v_s3[DIV_N-1];
			if (r_s5) v_s5 <= v_s4;
			if (r_s6) v_s6 <= v_s5;
			if (r_s7) v_s7 <= v_s6;
			if (r_s8) v_s8 <= v_s7;
			if (r_s9) v_s9 <= v_s8;
		end
	end

	// stage 1: charge and current products, mass times |M3|
	logic signed [63:0] pq_s1, pj1_s1, pj2_s1, pj3_s1;
	logic [62:0]        num_s1;
	logic signed [31:0] rho_s1, m3_s1, b1_s1, b2_s1, e3_s1;
	logic [31:0]        absm3;
	assign absm3 = in_ch.momentum_z[31] ? 32'(-in_ch.momentum_z) : in_ch.momentum_z;

	always_ff @(posedge clk) begin
		if (r_s1) begin
			pq_s1  <= in_ch.ion_density * $signed({1'b0, inv_q});
			pj1_s1 <= in_ch.momentum_x * $signed({1'b0, inv_q});
			pj2_s1 <= in_ch.momentum_y * $signed({1'b0, inv_q});
			pj3_s1 <= in_ch.momentum_z * $signed({1'b0, inv_q});
			num_s1 <= mass_q * absm3;
			rho_s1 <= in_ch.ion_density;
			m3_s1  <= in_ch.momentum_z;
			b1_s1  <= in_ch.field_bx;
			b2_s1  <= in_ch.field_by;
			e3_s1  <= in_ch.field_ez;
		end
	end

	// stage 2: round and clip q, J, start the divider
	carry_t      c_s2;
	logic [30:0] rem_s2, low_s2, den_s2;
	logic        ovf_s2;
	logic [32:0] sq, sj1, sj2, sj3;
	assign sq  = sat32(66'(rnd(pq_s1)));
	assign sj1 = sat32(66'(rnd(pj1_s1)));
	assign sj2 = sat32(66'(rnd(pj2_s1)));
	assign sj3 = sat32(66'(rnd(pj3_s1)));

	always_ff @(posedge clk) begin
		if (r_s2) begin
			c_s2.q    <= sq[31:0];
			c_s2.j1   <= sj1[31:0];
			c_s2.j2   <= sj2[31:0];
			c_s2.j3   <= sj3[31:0];
			c_s2.m3   <= m3_s1;
			c_s2.b1   <= b1_s1;
			c_s2.b2   <= b2_s1;
			c_s2.e3   <= e3_s1;
			c_s2.sat  <= sq[32] | sj1[32] | sj2[32] | sj3[32];
			c_s2.ramp <= slope_q != '0;
			c_s2.pos  <= !rho_s1[31] && rho_s1 != 32'sd0;
			den_s2    <= rho_s1[30:0];
			ovf_s2    <= num_s1[62:31] >= {1'b0, rho_s1[30:0]};
			rem_s2    <= num_s1[61:31];
			low_s2    <= num_s1[30:0];
		end
	end

	// stage 3: restoring divider, one quotient bit per stage
	carry_t      c_s3   [DIV_N];
	logic [30:0] rem_s3 [DIV_N];
	logic [30:0] low_s3 [DIV_N];
	logic [30:0] quo_s3 [DIV_N];
	logic [30:0] den_s3 [DIV_N];
	logic        ovf_s3 [DIV_N];

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		carry_t      c_in;
		logic [30:0] rem_in, low_in, quo_in, den_in;
		logic        ovf_in;
		logic [31:0] trial;
		logic        ge;
		if (k == 0) begin : g_first
			assign c_in   = c_s2;
			assign rem_in = rem_s2;
			assign low_in = low_s2;
			assign quo_in = '0;
			assign den_in = den_s2;
			assign ovf_in = ovf_s2;
		end else begin : g_next
			assign c_in   = c_s3[k-1];
			assign rem_in = rem_s3[k-1];
			assign low_in = low_s3[k-1];
			assign quo_in = quo_s3[k-1];
			assign den_in = den_s3[k-1];
			assign ovf_in = ovf_s3[k-1];
		end
		assign trial = {rem_in, low_in[30]};
		assign ge    = trial >= {1'b0, den_in};
		always_ff @(posedge clk) begin
			if (r_s3[k]) begin
				c_s3[k]   <= c_in;
				rem_s3[k] <= ge ? 31'(trial - {1'b0, den_in}) : trial[30:0];
				low_s3[k] <= {low_in[29:0], 1'b0};
				quo_s3[k] <= {quo_in[29:0], ge};
				den_s3[k] <= den_in;
				ovf_s3[k] <= ovf_in;
			end
		end
	end

	// stage 4: clip the trigger quantity and compare with the trigger level
	carry_t      c_s4;
	logic [30:0] diff_s4;
	logic        gt_s4;
	logic [30:0] mui;
	carry_t      c_last, c_last_f;
	assign c_last = c_s3[DIV_N-1];
	assign mui = ovf_s3[DIV_N-1] ? MAX31 : quo_s3[DIV_N-1];

	// fold the trigger quantity clip into the flag
	always_comb begin
		c_last_f     = c_last;
		c_last_f.sat = c_last.sat | (c_last.ramp & c_last.pos & ovf_s3[DIV_N-1]);
	end

	always_ff @(posedge clk) begin
		if (r_s4) begin
			c_s4     <= c_last_f;
			gt_s4    <= mui > trig_q;
			diff_s4  <= mui - trig_q;
		end
	end

	// stage 5: drag slope product
	carry_t      c_s5;
	logic [61:0] dprod_s5;
	logic        gt_s5;
	always_ff @(posedge clk) begin
		if (r_s5) begin
			c_s5     <= c_s4;
			gt_s5    <= gt_s4;
			dprod_s5 <= slope_q * diff_s4;
		end
	end

	// stage 6: round and clip the drag, pick the drag mode
	carry_t      c_s6;
	logic [30:0] drag_s6;
	logic        bad_s6;
	logic [63:0] dr;
	logic        dsat, ramp_on;
	carry_t      c_s5_f;
	assign dr      = (64'(dprod_s5) + HALF) >> FRAC_BITS;
	assign dsat    = dr > 64'(MAX31);
	assign ramp_on = c_s5.pos & gt_s5;

	// fold the drag clip into the flag
	always_comb begin
		c_s5_f     = c_s5;
		c_s5_f.sat = c_s5.sat | (c_s5.ramp & ramp_on & dsat);
	end

	always_ff @(posedge clk) begin
		if (r_s6) begin
			c_s6     <= c_s5_f;
			bad_s6   <= c_s5.ramp & !c_s5.pos;
			if (!c_s5.ramp) drag_s6 <= fixed_q;
			else if (!ramp_on) drag_s6 <= '0;
			else drag_s6 <= dsat ? MAX31 : dr[30:0];
		end
	end

	// stage 7: source products
	logic signed [63:0] pqe_s7, pj1b2_s7, pj2b1_s7, pdm_s7;
	logic signed [63:0] pj3b2_s7, pj3b1_s7, pj3e3_s7, pj3c_s7;
	logic               sat_s7, bad_s7;
	always_ff @(posedge clk) begin
		if (r_s7) begin
			pqe_s7   <= c_s6.q * c_s6.e3;
			pj1b2_s7 <= c_s6.j1 * c_s6.b2;
			pj2b1_s7 <= c_s6.j2 * c_s6.b1;
			pdm_s7   <= $signed({1'b0, drag_s6}) * c_s6.m3;
			pj3b2_s7 <= c_s6.j3 * c_s6.b2;
			pj3b1_s7 <= c_s6.j3 * c_s6.b1;
			pj3e3_s7 <= c_s6.j3 * c_s6.e3;
			pj3c_s7  <= c_s6.j3 * $signed({1'b0, lss_q});
			sat_s7   <= c_s6.sat;
			bad_s7   <= bad_s6;
		end
	end

	// stage 8: rounding
	logic signed [63:0] rx_s8, ry_s8, ra_s8, rb_s8, rc_s8, rd_s8, re_s8, rf_s8;
	logic               sat_s8, bad_s8;
	always_ff @(posedge clk) begin
		if (r_s8) begin
			rx_s8  <= rnd(-pj3b2_s7);
			ry_s8  <= rnd(pj3b1_s7);
			ra_s8  <= rnd(pqe_s7);
			rb_s8  <= rnd(pj1b2_s7);
			rc_s8  <= rnd(pj2b1_s7);
			rd_s8  <= rnd(pdm_s7);
			re_s8  <= rnd(pj3e3_s7);
			rf_s8  <= rnd(pj3c_s7);
			sat_s8 <= sat_s7;
			bad_s8 <= bad_s7;
		end
	end

	// stage 9: sum, clip and hold for the output beat
	logic [32:0] ox, oy, oz, oe, of;
	assign ox = sat32(66'(rx_s8));
	assign oy = sat32(66'(ry_s8));
	assign oz = sat32(66'(ra_s8) + 66'(rb_s8) - 66'(rc_s8) - 66'(rd_s8));
	assign oe = sat32(66'(re_s8));
	assign of = sat32(-(66'(rf_s8) <<< 1));

	logic signed [31:0] mx_s9, my_s9, mz_s9, en_s9, ef_s9;
	logic               sat_s9, bad_s9;
	always_ff @(posedge clk) begin
		if (r_s9) begin
			mx_s9  <= ox[31:0];
			my_s9  <= oy[31:0];
			mz_s9  <= oz[31:0];
			en_s9  <= oe[31:0];
			ef_s9  <= of[31:0];
			sat_s9 <= sat_s8 | ox[32] | oy[32] | oz[32] | oe[32] | of[32];
			bad_s9 <= bad_s8;
		end
	end

	assign out_ch.valid          = v_s9;
	assign out_ch.src_momentum_x = mx_s9;
	assign out_ch.src_momentum_y = my_s9;
	assign out_ch.src_momentum_z = mz_s9;
	assign out_ch.src_energy     = en_s9;
	assign out_ch.src_efield_z   = ef_s9;
	assign out_ch.saturated      = sat_s9;
	assign out_ch.bad_density    = bad_s9;

endmodule

### sim/tb_plasma_ion_source_term.sv
// self-checking testbench of the plasma ion source term block
module tb_plasma_ion_source_term;
	import pis_pkg::*;

	localparam int FB       = FRAC_BITS_DEF;
	localparam int N_PHASE  = 6;
	localparam int N_RAND   = 85;
	localparam int N_TOTAL  = N_PHASE * N_RAND + 20;
	localparam int DRAIN    = 45;
	localparam int MAX_SHOW = 10;

	typedef struct {
		logic signed [31:0] rho;
		logic signed [31:0] m1;
		logic signed [31:0] m2;
		logic signed [31:0] m3;
		logic signed [31:0] b1;
		logic signed [31:0] b2;
		logic signed [31:0] e3;
	} point_t;

	typedef struct {
		logic signed [31:0] smx;
		logic signed [31:0] smy;
		logic signed [31:0] smz;
		logic signed [31:0] sen;
		logic signed [31:0] sez;
		logic               sat;
		logic               bad;
	} sources_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	pis_in_if  in_ch ();
	pis_out_if out_ch ();

	plasma_ion_source_term dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	// register shadow
	longint mass_r, inv_r, lss_r, slope_r, fixed_r, trig_r;

	point_t   pending_points[$];
	sources_t expected_sources[$];
	point_t   cur_point;
	int       accepted_cnt;
	int       result_cnt;
	int       sat_cnt;
	int       bad_cnt;
	int       mismatch_cnt;
	int       idle_mode;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// saturate to the signed 32-bit range
	function automatic longint clip32(longint v, inout bit f);
		if (v > 64'sd2147483647) begin
			f = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// product rounded half up
	function automatic longint qmul(longint a, longint b);
		return (a * b + (64'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	// expected sources of one grid point
	function automatic sources_t calc_sources(point_t p);
		sources_t r;
		bit sat, bad;
		longint rho, m3, q, j1, j2, j3, drag, absm3, mui, d;
		longint v[5];
		sat = 1'b0;
		bad = 1'b0;
		drag = 0;
		rho = p.rho;
		m3 = p.m3;
		q = clip32(qmul(rho, inv_r), sat);
		j1 = clip32(qmul(longint'(p.m1), inv_r), sat);
		j2 = clip32(qmul(longint'(p.m2), inv_r), sat);
		j3 = clip32(qmul(m3, inv_r), sat);
		if (slope_r != 0) begin
			if (rho <= 0) begin
				bad = 1'b1;
			end else begin
				absm3 = (m3 < 0) ? -m3 : m3;
				mui = (mass_r * absm3) / rho;
				if (mui > 64'sd2147483647) begin
					mui = 64'sd2147483647;
					sat = 1'b1;
				end
				if (mui > trig_r) begin
					d = (slope_r * (mui - trig_r) + (64'sd1 <<< (FB - 1))) >>> FB;
					if (d > 64'sd2147483647) begin
						d = 64'sd2147483647;
						sat = 1'b1;
					end
					drag = d;
				end
			end
		end else begin
			drag = fixed_r;
		end
		v[0] = (-(j3 * longint'(p.b2)) + (64'sd1 <<< (FB - 1))) >>> FB;
		v[1] = qmul(j3, longint'(p.b1));
		v[2] = qmul(q, longint'(p.e3)) + qmul(j1, longint'(p.b2))
			- qmul(j2, longint'(p.b1)) - qmul(drag, m3);
		v[3] = qmul(j3, longint'(p.e3));
		v[4] = -2 * qmul(j3, lss_r);
		r.smx = clip32(v[0], sat);
		r.smy = clip32(v[1], sat);
		r.smz = clip32(v[2], sat);
		r.sen = clip32(v[3], sat);
		r.sez = clip32(v[4], sat);
		r.sat = sat;
		r.bad = bad;
		return r;
	endfunction

	// random field value: raw, moderate or an extreme
	function automatic logic [31:0] rnd_val(int kind);
		case (kind)
			0: begin
				return $urandom;
			end
			1: begin
				return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0;
					3: return 32'hffff_ffff;
					default: return 32'h0001_0000;
				endcase
			end
		endcase
	endfunction

	function automatic point_t rnd_point();
		point_t p;
		int k;
		k = $urandom_range(0, 99);
		if (k < 75) begin
			// physical point: positive density, moderate momenta and fields
			p.rho = $urandom_range(1, 32'h0040_0000);
			p.m1 = rnd_val(1);
			p.m2 = rnd_val(1);
			p.m3 = rnd_val(1);
			p.b1 = rnd_val(1);
			p.b2 = rnd_val(1);
			p.e3 = rnd_val(1);
		end else begin
			k = (k < 92) ? 0 : 2;
			p.rho = rnd_val(k);
			p.m1 = rnd_val(k);
			p.m2 = rnd_val(k);
			p.m3 = rnd_val(k);
			p.b1 = rnd_val(k);
			p.b2 = rnd_val(k);
			p.e3 = rnd_val(k);
		end
		return p;
	endfunction

	function automatic point_t mk_point(logic [31:0] rho, logic [31:0] m1, logic [31:0] m2,
		logic [31:0] m3, logic [31:0] b1, logic [31:0] b2, logic [31:0] e3);
		point_t p;
		p.rho = rho;
		p.m1 = m1;
		p.m2 = m2;
		p.m3 = m3;
		p.b1 = b1;
		p.b2 = b2;
		p.e3 = e3;
		return p;
	endfunction

	// register write, one per cycle
	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			IDX_ION_MASS:      mass_r = val;
			IDX_INV_ION_MASS:  inv_r = val;
			IDX_LIGHT_SPEED:   lss_r = val;
			IDX_SLOWING_SLOPE: slope_r = val;
			IDX_FIXED_RATE:    fixed_r = val;
			IDX_TRIGGER_LEVEL: trig_r = val;
			default: ;
		endcase
	endtask

	// values arrive as 32-bit words, the registers keep the low 31 bits
	task automatic set_regs(logic [31:0] ms, logic [31:0] inv, logic [31:0] ls,
		logic [31:0] sl, logic [31:0] fx, logic [31:0] tr);
		write_reg(IDX_ION_MASS, ms[CFG_W-1:0]);
		write_reg(IDX_INV_ION_MASS, inv[CFG_W-1:0]);
		write_reg(IDX_LIGHT_SPEED, ls[CFG_W-1:0]);
		write_reg(IDX_SLOWING_SLOPE, sl[CFG_W-1:0]);
		write_reg(IDX_FIXED_RATE, fx[CFG_W-1:0]);
		write_reg(IDX_TRIGGER_LEVEL, tr[CFG_W-1:0]);
		cfg_we <= 1'b0;
	endtask

	// wait until every point has left the block, then let the pipeline empty
	task automatic drain();
		while (pending_points.size() != 0 || in_ch.valid || expected_sources.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic add_random(int n);
		repeat (n) pending_points.push_back(rnd_point());
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			accepted_cnt <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_sources.push_back(calc_sources(cur_point));
				accepted_cnt <= accepted_cnt + 1;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_points.size() != 0 &&
					!(idle_mode == 0 && $urandom_range(0, 99) < 26) &&
					!(idle_mode == 1 && $urandom_range(0, 99) < 50)) begin
					cur_point = pending_points.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.ion_density <= cur_point.rho;
					in_ch.momentum_x <= cur_point.m1;
					in_ch.momentum_y <= cur_point.m2;
					in_ch.momentum_z <= cur_point.m3;
					in_ch.field_bx <= cur_point.b1;
					in_ch.field_by <= cur_point.b2;
					in_ch.field_ez <= cur_point.e3;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// idling pattern follows progress through the stimulus
	always_comb idle_mode = (accepted_cnt * 3) / N_TOTAL;

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		sources_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				result_cnt++;
				if (out_ch.saturated) sat_cnt++;
				if (out_ch.bad_density) bad_cnt++;
				if (expected_sources.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_SHOW)
						$display("unexpected result beat at %0t", $realtime);
				end else begin
					e = expected_sources.pop_front();
					if (e.smx !== out_ch.src_momentum_x || e.smy !== out_ch.src_momentum_y ||
						e.smz !== out_ch.src_momentum_z || e.sen !== out_ch.src_energy ||
						e.sez !== out_ch.src_efield_z || e.sat !== out_ch.saturated ||
						e.bad !== out_ch.bad_density) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MAX_SHOW)
							$display({"mismatch result %0d: exp %h %h %h %h %h s%b b%b",
								" got %h %h %h %h %h s%b b%b"},
								result_cnt, e.smx, e.smy, e.smz, e.sen, e.sez, e.sat, e.bad,
								out_ch.src_momentum_x, out_ch.src_momentum_y,
								out_ch.src_momentum_z, out_ch.src_energy,
								out_ch.src_efield_z, out_ch.saturated, out_ch.bad_density);
					end
				end
			end
			out_ch.ready <= (idle_mode == 0) ? ($urandom_range(0, 99) >= 50) :
				(idle_mode == 1) ? ($urandom_range(0, 99) >= 26) : 1'b1;
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// stimulus sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.ion_density = '0;
		in_ch.momentum_x = '0;
		in_ch.momentum_y = '0;
		in_ch.momentum_z = '0;
		in_ch.field_bx = '0;
		in_ch.field_by = '0;
		in_ch.field_ez = '0;
		out_ch.ready = 1'b0;
		result_cnt = 0;
		sat_cnt = 0;
		bad_cnt = 0;
		mismatch_cnt = 0;
		mass_r = 64'sd1 <<< FB;
		inv_r = 64'sd1 <<< FB;
		lss_r = 64'sd1 <<< FB;
		slope_r = 0;
		fixed_r = 0;
		trig_r = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: field extremes and saturation
		pending_points.push_back(mk_point(32'h0001_0000, 32'h0002_0000, 32'hfffe_0000,
			32'h0003_0000, 32'h0000_8000, 32'hffff_8000, 32'h0001_8000));
		pending_points.push_back(mk_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		pending_points.push_back(mk_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		pending_points.push_back(mk_point(0, 0, 0, 0, 0, 0, 0));
		pending_points.push_back(mk_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'h0000_8000, 32'hffff_ffff, 32'h0000_0001, 32'hffff_8000));
		add_random(N_RAND);
		drain();

		// ramp drag: negative and zero density, trigger not reached, ramp active
		set_regs(32'h0001_0000, 32'h0000_8000, 32'h0003_0000, 32'h0000_8000, 0,
			32'h0002_0000);
		pending_points.push_back(mk_point(32'hffff_0000, 32'h1_0000, 0, 32'h4_0000, 0, 0, 0));
		pending_points.push_back(mk_point(0, 0, 32'h1_0000, 32'h4_0000, 32'h1_0000, 0, 0));
		pending_points.push_back(mk_point(32'h8000_0000, 0, 0, 32'h1_0000, 0, 0, 0));
		pending_points.push_back(mk_point(32'h1_0000, 0, 0, 32'h2_0000, 0, 0, 0));
		pending_points.push_back(mk_point(32'h1_0000, 0, 0, 32'hfffe_0000, 0, 0, 0));
		pending_points.push_back(mk_point(32'h1_0000, 0, 0, 32'h0a_0000, 32'h1_0000, 0, 0));
		pending_points.push_back(mk_point(32'h1_0000, 0, 0, 32'hfff6_0000, 0, 32'h1_0000, 0));
		pending_points.push_back(mk_point(32'h1, 0, 0, 32'h7fff_ffff, 0, 0, 0));
		pending_points.push_back(mk_point(32'h1, 0, 0, 32'h8000_0000, 0, 0, 32'h1_0000));
		add_random(N_RAND);
		drain();

		// fixed drag rate
		set_regs(32'h0002_0000, 32'h0001_0000, 32'h0000_4000, 0, 32'h0000_2000, 32'h7fff_ffff);
		pending_points.push_back(mk_point(32'hffff_0000, 0, 0, 32'h4_0000, 0, 0, 0));
		pending_points.push_back(mk_point(32'h1_0000, 0, 0, 32'h8000_0000, 0, 0, 0));
		add_random(N_RAND);
		drain();

		// every register at its maximum
		set_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff);
		pending_points.push_back(mk_point(32'h1, 32'h1, 32'h1, 32'h8000_0000, 32'h1, 32'h1, 32'h1));
		add_random(N_RAND);
		drain();

		// every register zero, plus a write to an unused index
		set_regs(0, 0, 0, 0, 0, 0);
		write_reg(cfg_idx_t'(3'd6), 31'h1234_5678);
		cfg_we <= 1'b0;
		pending_points.push_back(mk_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
		add_random(N_RAND);
		drain();

		// random settings, ramp mode with a low trigger
		set_regs($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0004_0000),
			$urandom, $urandom_range(1, 32'h0010_0000), $urandom,
			$urandom_range(0, 32'h0008_0000));
		add_random(N_RAND);
		drain();

		$display("covered %0d points over six register settings, %0d results checked",
			accepted_cnt, result_cnt);
		$display("%0d results saturated, %0d with bad density, %0d mismatches",
			sat_cnt, bad_cnt, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_sources.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
